/* design/ofv_pkg.sv */
// ofv_pkg: shared constants, register indexes and control types for the
// optical flow velocity update core. No dependencies.
package ofv_pkg;

    localparam int LINE_MAX_DEF  = 1024;
    localparam int ROWS_MAX_DEF  = 1024;
    localparam int FRAC_BITS_DEF = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SQ     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_ROW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_COL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_COL     = 3'd6;

    localparam logic [31:0] ALPHA_SQ_RST     = 32'd65536;
    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [10:0] FRAME_HEIGHT_RST = 11'd480;
    localparam logic [9:0]  FIRST_ROW_RST    = 10'd1;
    localparam logic [9:0]  LAST_ROW_RST     = 10'd478;
    localparam logic [9:0]  FIRST_COL_RST    = 10'd1;
    localparam logic [9:0]  LAST_COL_RST     = 10'd638;

    localparam int PIX_W  = 32;
    localparam int GRAD_W = 48;
    localparam int LINE_W = 2 * PIX_W + GRAD_W;

    // divider: quotient bits kept before the result is known to saturate
    localparam int QUOT_BITS = 18;
    localparam int DIV_W     = 64;

    // x/3 as (x * RECIP_3) >> RECIP_SHIFT, exact for x below 2^19
    localparam logic [18:0] RECIP_3     = 19'd349526;
    localparam int          RECIP_SHIFT = 20;
    localparam logic [19:0] ROUND_12    = 20'd6;

    typedef struct packed {
        logic load;
        logic zero;
        logic shift;
        logic avg;
        logic mul;
        logic sum;
        logic prd;
        logic div_start;
        logic div_v;
        logic cap_u;
        logic cap_v;
        logic out_load;
        logic pass;
        logic fend;
    } t_ofv_cmd;

    typedef struct packed {
        logic div_done;
        logic div_busy;
    } t_ofv_sts;

endpackage

/* design/ofv_ram.sv */
// ofv_ram: generic simple dual port ram, one write and one registered read.
// No dependencies.
module ofv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* design/ofv_div.sv */
// ofv_div: shared restoring divider, rounded to nearest, one quotient bit per cycle.
// Quotients past 2^QUOT_BITS are flagged as that value. Depends on ofv_pkg.
module ofv_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [ofv_pkg::DIV_W-1:0]   i_num,
    input  logic [ofv_pkg::DIV_W-1:0]          i_den,
    output logic                               o_done,
    output logic                               o_busy,
    output logic signed [ofv_pkg::QUOT_BITS+1:0] o_quot
);
    localparam int DW = ofv_pkg::DIV_W;
    localparam int QB = ofv_pkg::QUOT_BITS;
    localparam int CNTW = $clog2(QB);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CHK  = 2'd1;
    localparam logic [1:0] PH_ITER = 2'd2;

    logic [1:0]       r_phase;
    logic             r_done;
    logic             r_neg;
    logic             r_big;
    logic [DW-1:0]    r_rem;
    logic [DW+QB-1:0] r_ds;
    logic [QB-1:0]    r_q;
    logic [CNTW-1:0]  r_cnt;
    logic [DW-1:0]    w_mag;
    logic [DW+QB-1:0] w_rem_ext;
    logic             w_ge;
    logic [QB:0]      w_qmag;

    assign w_mag     = (i_num < 0) ? DW'(-i_num) : DW'(i_num);
    assign w_rem_ext = {{QB{1'b0}}, r_rem};
    assign w_ge      = w_rem_ext >= r_ds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_num < 0;
                        r_rem   <= w_mag + (i_den >> 1);
                        r_ds    <= {i_den, {QB{1'b0}}};
                        r_phase <= PH_CHK;
                    end
                end
                PH_CHK: begin
                    r_q <= '0;
                    if (r_ds == '0) begin
                        // zero divisor: no correction
                        r_big   <= 1'b0;
                        r_done  <= 1'b1;
                        r_phase <= PH_IDLE;
                    end else if (w_ge) begin
                        r_big   <= 1'b1;
                        r_done  <= 1'b1;
                        r_phase <= PH_IDLE;
                    end else begin
                        r_big   <= 1'b0;
                        r_ds    <= r_ds >> 1;
                        r_cnt   <= CNTW'(QB - 1);
                        r_phase <= PH_ITER;
                    end
                end
                PH_ITER: begin
                    if (w_ge) begin
                        r_rem <= r_rem - r_ds[DW-1:0];
                    end
                    r_q  <= {r_q[QB-2:0], w_ge};
                    r_ds <= r_ds >> 1;
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_phase <= PH_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    assign w_qmag = r_big ? {1'b1, {QB{1'b0}}} : {1'b0, r_q};
    assign o_quot = r_neg ? -$signed({1'b0, w_qmag}) : $signed({1'b0, w_qmag});
    assign o_done = r_done;
    assign o_busy = r_phase != PH_IDLE;
endmodule

/* design/ofv_dp.sv */
// ofv_dp: datapath with line buffers, 3x3 window, neighbour averages, products,
// shared divider and output registers. Depends on ofv_pkg, ofv_ram, ofv_div.
module ofv_dp #(
    parameter int LINE_MAX  = ofv_pkg::LINE_MAX_DEF,
    parameter int FRAC_BITS = ofv_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ofv_pkg::t_ofv_cmd                 i_cmd,
    output ofv_pkg::t_ofv_sts                 o_sts,
    input  logic [$clog2(LINE_MAX)-1:0]       i_addr,
    input  logic signed [15:0]                i_u_prev,
    input  logic signed [15:0]                i_v_prev,
    input  logic signed [15:0]                i_grad_x,
    input  logic signed [15:0]                i_grad_y,
    input  logic signed [15:0]                i_grad_t,
    input  logic                              i_cfg_we,
    input  logic [ofv_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ofv_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic signed [15:0]                o_u_new,
    output logic signed [15:0]                o_v_new,
    output logic                              o_passed_through,
    output logic                              o_frame_end
);
    localparam int AW = $clog2(LINE_MAX);
    localparam int ALPHA_UP = (2 * FRAC_BITS >= 16) ? (2 * FRAC_BITS - 16) : 0;
    localparam int ALPHA_DN = (2 * FRAC_BITS < 16) ? (16 - 2 * FRAC_BITS) : 0;
    localparam int QW = ofv_pkg::QUOT_BITS + 2;
    localparam int DW = ofv_pkg::DIV_W;

    logic [31:0]                    r_alpha;
    logic [ofv_pkg::PIX_W-1:0]      r_newpix;
    logic [ofv_pkg::GRAD_W-1:0]     r_newgrad;
    logic [ofv_pkg::LINE_W-1:0]     w_rd;
    logic [ofv_pkg::PIX_W-1:0]      r_win [9];
    logic [ofv_pkg::GRAD_W-1:0]     r_gdly;
    logic [ofv_pkg::GRAD_W-1:0]     r_cg;
    logic signed [15:0]             r_ub;
    logic signed [15:0]             r_vb;
    logic signed [31:0]             r_pxu;
    logic signed [31:0]             r_pyv;
    logic [31:0]                    r_sqx;
    logic [31:0]                    r_sqy;
    logic signed [35:0]             r_p;
    logic [DW-1:0]                  r_den;
    logic signed [51:0]             r_nu;
    logic signed [51:0]             r_nv;
    logic signed [15:0]             r_un;
    logic signed [15:0]             r_vn;
    logic signed [15:0]             r_uo;
    logic signed [15:0]             r_vo;
    logic                           r_pass;
    logic                           r_fend;
    logic signed [15:0]             w_ex;
    logic signed [15:0]             w_ey;
    logic signed [15:0]             w_et;
    logic [8:0][15:0]               w_lo;
    logic [8:0][15:0]               w_hi;
    logic signed [QW-1:0]           w_quot;
    logic                           w_div_done;
    logic                           w_div_busy;
    logic signed [DW-1:0]           w_num;

    function automatic logic signed [15:0] nb_avg(input logic [8:0][15:0] w);
        logic signed [20:0] s;
        logic [19:0]        m;
        logic [17:0]        x;
        logic [37:0]        pr;
        logic [15:0]        q;
        s = 21'(2) * (21'($signed(w[1])) + 21'($signed(w[3])) + 21'($signed(w[5]))
            + 21'($signed(w[7]))) + 21'($signed(w[0])) + 21'($signed(w[2]))
            + 21'($signed(w[6])) + 21'($signed(w[8]));
        m  = (s < 0) ? 20'(-s) : 20'(s);
        x  = 18'((m + ofv_pkg::ROUND_12) >> 2);
        pr = 38'(x) * 38'(ofv_pkg::RECIP_3);
        q  = 16'(pr >> ofv_pkg::RECIP_SHIFT);
        return (s < 0) ? $signed(-q) : $signed(q);
    endfunction

    function automatic logic signed [15:0] sat_sub(input logic signed [15:0] a,
                                                   input logic signed [QW-1:0] b);
        logic signed [QW:0] d;
        d = (QW+1)'(a) - (QW+1)'(b);
        if (d > 32767) begin
            return 16'sh7fff;
        end else if (d < -32768) begin
            return 16'sh8000;
        end
        return 16'(d);
    endfunction

    ofv_ram #(
        .WIDTH (ofv_pkg::LINE_W),
        .DEPTH (LINE_MAX)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (i_addr[AW-1:0]),
        .i_wdata ({r_newgrad, r_newpix, w_rd[63:32]}),
        .i_re    (i_cmd.load),
        .i_raddr (i_addr[AW-1:0]),
        .o_rdata (w_rd)
    );

    assign w_ex = $signed(r_cg[15:0]);
    assign w_ey = $signed(r_cg[31:16]);
    assign w_et = $signed(r_cg[47:32]);
    assign w_num = i_cmd.div_v ? DW'(r_nv) : DW'(r_nu);

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            w_lo[i] = r_win[i][15:0];
            w_hi[i] = r_win[i][31:16];
        end
    end

    ofv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ofv_pkg::ALPHA_SQ_RST;
            r_gdly  <= '0;
            r_cg    <= '0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cfg_we && i_cfg_idx == ofv_pkg::CFG_ALPHA_SQ) begin
                r_alpha <= i_cfg_data;
            end
            if (i_cmd.shift) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= w_rd[31:0];
                r_win[3] <= r_win[4];
                r_win[4] <= r_win[5];
                r_win[5] <= w_rd[63:32];
                r_win[6] <= r_win[7];
                r_win[7] <= r_win[8];
                r_win[8] <= r_newpix;
                r_cg     <= r_gdly;
                r_gdly   <= w_rd[111:64];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            // tail items carry nothing into the line buffers
            r_newpix  <= i_cmd.zero ? '0 : {i_v_prev, i_u_prev};
            r_newgrad <= i_cmd.zero ? '0 : {i_grad_t, i_grad_y, i_grad_x};
        end
        if (i_cmd.avg) begin
            r_ub <= nb_avg(w_lo);
            r_vb <= nb_avg(w_hi);
        end
        if (i_cmd.mul) begin
            r_pxu <= w_ex * r_ub;
            r_pyv <= w_ey * r_vb;
            r_sqx <= 32'(32'(w_ex) * 32'(w_ex));
            r_sqy <= 32'(32'(w_ey) * 32'(w_ey));
        end
        if (i_cmd.sum) begin
            r_p   <= 36'(r_pxu) + 36'(r_pyv) + (36'(w_et) <<< FRAC_BITS);
            r_den <= ((DW'(r_alpha) << ALPHA_UP) >> ALPHA_DN) + DW'(r_sqx) + DW'(r_sqy);
        end
        if (i_cmd.prd) begin
            r_nu <= 52'(w_ex) * 52'(r_p);
            r_nv <= 52'(w_ey) * 52'(r_p);
        end
        if (i_cmd.cap_u) begin
            r_un <= sat_sub(r_ub, w_quot);
        end
        if (i_cmd.cap_v) begin
            r_vn <= sat_sub(r_vb, w_quot);
        end
        if (i_cmd.out_load) begin
            r_uo   <= i_cmd.pass ? $signed(r_win[4][15:0]) : r_un;
            r_vo   <= i_cmd.pass ? $signed(r_win[4][31:16]) : r_vn;
            r_pass <= i_cmd.pass;
            r_fend <= i_cmd.fend;
        end
    end

    assign o_sts.div_done   = w_div_done;
    assign o_sts.div_busy   = w_div_busy;
    assign o_u_new          = r_uo;
    assign o_v_new          = r_vo;
    assign o_passed_through = r_pass;
    assign o_frame_end      = r_fend;
endmodule

/* design/ofv_ctrl.sv */
// ofv_ctrl: sequencer, frame position counters, bounds registers and output valid.
// Depends on ofv_pkg.
module ofv_ctrl #(
    parameter int LINE_MAX = ofv_pkg::LINE_MAX_DEF,
    parameter int ROWS_MAX = ofv_pkg::ROWS_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_drain,
    output logic                            o_valid,
    input  logic                            i_ready,
    input  logic                            i_cfg_we,
    input  logic [ofv_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ofv_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output ofv_pkg::t_ofv_cmd               o_cmd,
    output logic [$clog2(LINE_MAX)-1:0]     o_addr,
    input  ofv_pkg::t_ofv_sts               i_sts
);
    localparam int AW = $clog2(LINE_MAX);
    localparam int CW = $clog2(LINE_MAX + 1);
    localparam int RW = $clog2(ROWS_MAX + 2);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_WIN  = 4'd2;
    localparam logic [3:0] S_AVG  = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_SUM  = 4'd5;
    localparam logic [3:0] S_PRD  = 4'd6;
    localparam logic [3:0] S_DU0  = 4'd7;
    localparam logic [3:0] S_DU   = 4'd8;
    localparam logic [3:0] S_DV0  = 4'd9;
    localparam logic [3:0] S_DV   = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          r_upd, n_upd;
    logic          r_fend, n_fend;
    logic          r_ovalid, n_ovalid;
    logic [10:0]   r_fw;
    logic [10:0]   r_fh;
    logic [9:0]    r_frow;
    logic [9:0]    r_lrow;
    logic [9:0]    r_fcol;
    logic [9:0]    r_lcol;
    logic [CW-1:0] w_w;
    logic [RW-1:0] w_h;
    logic [RW-1:0] w_orow;
    logic [CW-1:0] w_ocol;
    logic [CW-1:0] w_col_inc;
    logic          w_tail;
    logic          w_emit;
    logic          w_upd;
    logic          w_fend;
    logic          w_accept;
    logic          w_size_wr;

    always_comb begin
        if (r_fw < 11'd3) begin
            w_w = CW'(3);
        end else if (32'(r_fw) > 32'(LINE_MAX)) begin
            w_w = CW'(LINE_MAX);
        end else begin
            w_w = CW'(r_fw);
        end
        if (r_fh < 11'd3) begin
            w_h = RW'(3);
        end else if (32'(r_fh) > 32'(ROWS_MAX)) begin
            w_h = RW'(ROWS_MAX);
        end else begin
            w_h = RW'(r_fh);
        end
    end

    assign w_accept  = i_valid && o_ready;
    assign w_tail    = 32'(r_row) >= 32'(w_h);
    assign w_emit    = !(r_row == '0 || (r_row == RW'(1) && r_col == '0));
    assign w_orow    = (r_col != '0) ? r_row - RW'(1) : r_row - RW'(2);
    assign w_ocol    = (r_col != '0) ? r_col - CW'(1) : w_w - CW'(1);
    assign w_col_inc = r_col + CW'(1);
    assign w_size_wr = i_cfg_we && (i_cfg_idx == ofv_pkg::CFG_FRAME_WIDTH ||
                                    i_cfg_idx == ofv_pkg::CFG_FRAME_HEIGHT);

    // interior of the frame and inside the programmed window
    assign w_upd = 32'(w_orow) >= 32'd1 && 32'(w_orow) + 32'd2 <= 32'(w_h) &&
                   32'(w_ocol) >= 32'd1 && 32'(w_ocol) + 32'd2 <= 32'(w_w) &&
                   32'(w_orow) >= 32'(r_frow) && 32'(w_orow) <= 32'(r_lrow) &&
                   32'(w_ocol) >= 32'(r_fcol) && 32'(w_ocol) <= 32'(r_lcol);
    assign w_fend = 32'(w_orow) == 32'(w_h) - 32'd1 && 32'(w_ocol) == 32'(w_w) - 32'd1;

    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_row    = r_row;
        n_upd    = r_upd;
        n_fend   = r_fend;
        n_ovalid = r_ovalid && !i_ready;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept && !(i_drain && !w_tail)) begin
                    o_cmd.load = 1'b1;
                    o_cmd.zero = w_tail;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                n_state = S_WIN;
            end
            S_WIN: begin
                o_cmd.shift = 1'b1;
                if (32'(w_col_inc) >= 32'(w_w)) begin
                    n_col = '0;
                    n_row = r_row + RW'(1);
                end else begin
                    n_col = w_col_inc;
                end
                n_upd  = w_upd;
                n_fend = w_fend;
                if (!w_emit) begin
                    n_state = S_IDLE;
                end else begin
                    if (w_fend) begin
                        n_col = '0;
                        n_row = '0;
                    end
                    n_state = w_upd ? S_AVG : S_OUT;
                end
            end
            S_AVG: begin
                o_cmd.avg = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_PRD;
            end
            S_PRD: begin
                o_cmd.prd = 1'b1;
                n_state   = S_DU0;
            end
            S_DU0: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DU;
            end
            S_DU: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_u = 1'b1;
                    n_state     = S_DV0;
                end
            end
            S_DV0: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_v     = 1'b1;
                n_state         = S_DV;
            end
            S_DV: begin
                if (i_sts.div_done) begin
                    o_cmd.cap_v = 1'b1;
                    n_state     = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.pass     = !r_upd;
                    o_cmd.fend     = r_fend;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_size_wr) begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_col    <= '0;
            r_row    <= '0;
            r_upd    <= 1'b0;
            r_fend   <= 1'b0;
            r_ovalid <= 1'b0;
            r_fw     <= ofv_pkg::FRAME_WIDTH_RST;
            r_fh     <= ofv_pkg::FRAME_HEIGHT_RST;
            r_frow   <= ofv_pkg::FIRST_ROW_RST;
            r_lrow   <= ofv_pkg::LAST_ROW_RST;
            r_fcol   <= ofv_pkg::FIRST_COL_RST;
            r_lcol   <= ofv_pkg::LAST_COL_RST;
        end else begin
            r_state  <= n_state;
            r_col    <= n_col;
            r_row    <= n_row;
            r_upd    <= n_upd;
            r_fend   <= n_fend;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ofv_pkg::CFG_FRAME_WIDTH:  r_fw   <= i_cfg_data[10:0];
                    ofv_pkg::CFG_FRAME_HEIGHT: r_fh   <= i_cfg_data[10:0];
                    ofv_pkg::CFG_FIRST_ROW:    r_frow <= i_cfg_data[9:0];
                    ofv_pkg::CFG_LAST_ROW:     r_lrow <= i_cfg_data[9:0];
                    ofv_pkg::CFG_FIRST_COL:    r_fcol <= i_cfg_data[9:0];
                    ofv_pkg::CFG_LAST_COL:     r_lcol <= i_cfg_data[9:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_ready = r_state == S_IDLE;
    assign o_valid = r_ovalid;
    assign o_addr  = r_col[AW-1:0];

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < 32'(w_w))
        else $error("column counter past frame width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) <= 32'(w_h) + 32'd1)
        else $error("row counter past frame tail");

    a_fend_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load && o_cmd.fend |-> r_col == '0 && r_row == '0)
        else $error("frame end without position restart");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_sts.div_busy)
        else $error("divider started while busy");
endmodule

/* design/optical_flow_velocity_update_core.sv */
// optical_flow_velocity_update_core: one horn-schunck velocity update pass over
// a raster-order frame. Depends on ofv_pkg, ofv_ctrl, ofv_dp.
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  input   | i_valid / o_ready   | i_u_prev i_v_prev i_grad_x i_grad_y i_grad_t i_drain
//  output  | o_valid / i_ready   | o_u_new o_v_new o_passed_through o_frame_end
//  config  | i_cfg_we            | i_cfg_idx i_cfg_data
//
// one item at a time: a pixel with no result passes through the read and window
// states, a copied pixel then loads the output, and an updated pixel runs the
// shared divider twice (start, range check, 18 bits, done) before the output;
// a quotient known to saturate ends a divider pass after the range check.
// line buffer read is registered, so each item passes through a read state.
// synchronous active-low reset; line buffers are not cleared.
// a result waiting on i_ready does not block the next transfer in; the block
// stalls only when the following result is ready and the output is still full.
module optical_flow_velocity_update_core #(
    parameter int LINE_MAX  = ofv_pkg::LINE_MAX_DEF,
    parameter int ROWS_MAX  = ofv_pkg::ROWS_MAX_DEF,
    parameter int FRAC_BITS = ofv_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [15:0]              i_u_prev,
    input  logic signed [15:0]              i_v_prev,
    input  logic signed [15:0]              i_grad_x,
    input  logic signed [15:0]              i_grad_y,
    input  logic signed [15:0]              i_grad_t,
    input  logic                            i_drain,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [15:0]              o_u_new,
    output logic signed [15:0]              o_v_new,
    output logic                            o_passed_through,
    output logic                            o_frame_end,
    input  logic                            i_cfg_we,
    input  logic [ofv_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ofv_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    ofv_pkg::t_ofv_cmd              w_cmd;
    ofv_pkg::t_ofv_sts              w_sts;
    logic [$clog2(LINE_MAX)-1:0]    w_addr;

    ofv_ctrl #(
        .LINE_MAX (LINE_MAX),
        .ROWS_MAX (ROWS_MAX)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_drain    (i_drain),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cmd      (w_cmd),
        .o_addr     (w_addr),
        .i_sts      (w_sts)
    );

    ofv_dp #(
        .LINE_MAX  (LINE_MAX),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_addr           (w_addr),
        .i_u_prev         (i_u_prev),
        .i_v_prev         (i_v_prev),
        .i_grad_x         (i_grad_x),
        .i_grad_y         (i_grad_y),
        .i_grad_t         (i_grad_t),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_u_new          (o_u_new),
        .o_v_new          (o_v_new),
        .o_passed_through (o_passed_through),
        .o_frame_end      (o_frame_end)
    );
endmodule

/* bench/tb.sv */
// tb: self-checking bench for optical_flow_velocity_update_core, built on a
// predictor of the velocity update that checks every output transfer.
// Depends on ofv_pkg and the core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 100;
    localparam int RAND_ITEMS  = 1450;
    localparam int WIDE_ITEMS  = 1040;
    localparam int RAND_END    = RAND_ITEMS - WIDE_ITEMS;

    typedef struct packed {
        logic [15:0] u;
        logic [15:0] v;
        logic [15:0] gx;
        logic [15:0] gy;
        logic [15:0] gt;
        logic        drain;
    } t_pix_item;

    typedef struct packed {
        logic [15:0] u;
        logic [15:0] v;
        logic        pass;
        logic        fend;
    } t_vel_res;

    typedef struct packed {
        t_pix_item it;
        logic      typed;
        t_vel_res  r;
    } t_dir_row;

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic i_valid = 1'b0, i_ready = 1'b0, i_drain = 1'b0;
    logic signed [15:0] i_u_prev = '0, i_v_prev = '0, i_grad_x = '0, i_grad_y = '0;
    logic signed [15:0] i_grad_t = '0;
    logic i_cfg_we = 1'b0;
    logic [ofv_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [ofv_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_ready, o_valid, o_passed_through, o_frame_end;
    logic signed [15:0] o_u_new, o_v_new;

    optical_flow_velocity_update_core dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] p_alpha;
    logic [10:0] p_width, p_height;
    logic [9:0]  p_frow, p_lrow, p_fcol, p_lcol;
    logic [31:0] up_ln [1024];
    logic [31:0] mid_ln [1024];
    logic [47:0] grad_ln [1024];
    logic [31:0] win [9];
    logic [47:0] grad_dly;
    int unsigned col_n, row_n;

    t_vel_res vel_expected [$];
    int errors = 0, items_sent = 0, results_seen = 0, updated_seen = 0;
    int send_idle = 0, recv_idle = 0;
    bit hold_req = 0, hold_done = 0;
    int hold_cnt = 0;

    function automatic longint rnd_div(longint n, longint unsigned d);
        longint unsigned mag, q;
        if (d == 0) return 0;
        mag = (n < 0) ? longint'(-n) : longint'(n);
        q = (mag + d / 2) / d;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [15:0] sat16(longint x);
        if (x > 32767) return 16'h7fff;
        if (x < -32768) return 16'h8000;
        return x[15:0];
    endfunction

    function automatic longint nb_avg(bit hi);
        longint w [9];
        longint num;
        for (int i = 0; i < 9; i++)
            w[i] = hi ? longint'($signed(win[i][31:16])) : longint'($signed(win[i][15:0]));
        num = 2 * (w[1] + w[3] + w[5] + w[7]) + (w[0] + w[2] + w[6] + w[8]);
        return rnd_div(num, 12);
    endfunction

    function automatic int unsigned clamp_sz(logic [10:0] x);
        if (x < 3) return 3;
        if (x > 1024) return 1024;
        return 32'(x);
    endfunction

    function automatic void vel_cfg(logic [ofv_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        case (idx)
            ofv_pkg::CFG_ALPHA_SQ:     p_alpha = val;
            ofv_pkg::CFG_FRAME_WIDTH:  begin p_width = val[10:0]; col_n = 0; row_n = 0; end
            ofv_pkg::CFG_FRAME_HEIGHT: begin p_height = val[10:0]; col_n = 0; row_n = 0; end
            ofv_pkg::CFG_FIRST_ROW:    p_frow = val[9:0];
            ofv_pkg::CFG_LAST_ROW:     p_lrow = val[9:0];
            ofv_pkg::CFG_FIRST_COL:    p_fcol = val[9:0];
            ofv_pkg::CFG_LAST_COL:     p_lcol = val[9:0];
            default: ;
        endcase
    endfunction

    function automatic bit vel_predict(t_pix_item it, output t_vel_res r);
        int unsigned w, h, c, rw, orow, ocol;
        bit tail, upd;
        logic [31:0] newpix;
        logic [47:0] newgrad, cgrad;
        longint ex, ey, et, ub, vb, p;
        longint unsigned d;
        r = '0;
        w = clamp_sz(p_width);
        h = clamp_sz(p_height);
        if (col_n >= w) col_n = 0;
        tail = row_n >= h;
        if (it.drain && !tail) return 0;
        newpix = tail ? '0 : {it.v, it.u};
        newgrad = tail ? '0 : {it.gt, it.gy, it.gx};
        c = col_n;
        rw = row_n;
        win[0] = win[1]; win[1] = win[2];
        win[3] = win[4]; win[4] = win[5];
        win[6] = win[7]; win[7] = win[8];
        win[2] = up_ln[c];
        win[5] = mid_ln[c];
        win[8] = newpix;
        up_ln[c] = mid_ln[c];
        mid_ln[c] = newpix;
        cgrad = grad_dly;
        grad_dly = grad_ln[c];
        grad_ln[c] = newgrad;
        col_n = c + 1;
        if (col_n >= w) begin
            col_n = 0;
            row_n = rw + 1;
        end
        if (rw == 0 || (rw == 1 && c == 0)) return 0;
        if (c >= 1) begin
            orow = rw - 1; ocol = c - 1;
        end else begin
            orow = rw - 2; ocol = w - 1;
        end
        upd = orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w &&
              orow >= p_frow && orow <= p_lrow && ocol >= p_fcol && ocol <= p_lcol;
        if (upd) begin
            ex = $signed(cgrad[15:0]);
            ey = $signed(cgrad[31:16]);
            et = $signed(cgrad[47:32]);
            ub = nb_avg(0);
            vb = nb_avg(1);
            p = ex * ub + ey * vb + et * 256;
            d = longint'(p_alpha) + longint'(ex * ex) + longint'(ey * ey);
            r.u = sat16(ub - rnd_div(ex * p, d));
            r.v = sat16(vb - rnd_div(ey * p, d));
        end else begin
            r.u = win[4][15:0];
            r.v = win[4][31:16];
        end
        r.pass = !upd;
        r.fend = orow == h - 1 && ocol == w - 1;
        if (r.fend) begin
            col_n = 0;
            row_n = 0;
        end
        return 1;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // output checker
    always @(posedge i_clk) begin
        t_vel_res e;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (!o_passed_through) updated_seen++;
            if (vel_expected.size() == 0) begin
                report_mismatch("unexpected transfer", o_u_new, '0);
            end else begin
                e = vel_expected.pop_front();
                if (o_u_new !== e.u) report_mismatch("u_new", o_u_new, e.u);
                if (o_v_new !== e.v) report_mismatch("v_new", o_v_new, e.v);
                if (o_passed_through !== e.pass)
                    report_mismatch("passed_through", o_passed_through, e.pass);
                if (o_frame_end !== e.fend) report_mismatch("frame_end", o_frame_end, e.fend);
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_cnt = 400;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom % 100) >= recv_idle;
        end
    end

    // watchdog on cycles with no transfer on either channel
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) quiet = 0;
        else quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet);
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(t_pix_item it, bit typed, t_vel_res tr);
        t_vel_res r;
        @(negedge i_clk);
        while (($urandom % 100) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_u_prev <= it.u;
        i_v_prev <= it.v;
        i_grad_x <= it.gx;
        i_grad_y <= it.gy;
        i_grad_t <= it.gt;
        i_drain  <= it.drain;
        do @(posedge i_clk); while (!o_ready);
        if (vel_predict(it, r)) vel_expected.push_back(typed ? tr : r);
        items_sent++;
        if (items_sent == 200) hold_req = 1;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (vel_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [31:0] a, logic [10:0] w, logic [10:0] h,
                              logic [9:0] fr, logic [9:0] lr, logic [9:0] fc, logic [9:0] lc);
        logic [31:0] vals [7];
        vals = '{a, 32'(w), 32'(h), 32'(fr), 32'(lr), 32'(fc), 32'(lc)};
        for (int i = ofv_pkg::CFG_ALPHA_SQ; i <= ofv_pkg::CFG_LAST_COL; i++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= ofv_pkg::CFG_IDX_W'(i);
            i_cfg_data <= vals[i];
            vel_cfg(ofv_pkg::CFG_IDX_W'(i), vals[i]);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rnd16();
        case ($urandom % 4)
            0: case ($urandom % 4)
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'h0000;
                default: return 16'hffff;
            endcase
            1: return 16'($signed($urandom_range(0, 2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_pix_item rnd_item(bit drain);
        t_pix_item it;
        it = {rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), drain};
        // zero divisor case when the weight is zero too
        if (p_alpha == 0 && ($urandom % 3) == 0) begin
            it.gx = '0;
            it.gy = '0;
        end
        return it;
    endfunction

    // one frame of pixels and its tail, cut short when abort is set
    task automatic run_frame(bit abort);
        int unsigned w, h, n_all, n_stop;
        w = clamp_sz(p_width);
        h = clamp_sz(p_height);
        n_all = h * w + w + 1;
        n_stop = abort ? $urandom_range(1, n_all - 1) : n_all;
        for (int unsigned n = 0; n < n_stop; n++) begin
            if (n < h * w && ($urandom % 20) == 0) send_item(rnd_item(1), 0, '0);
            send_item(rnd_item(n >= h * w && ($urandom % 4) != 0), 0, '0);
        end
    endtask

    t_dir_row dir_tab [14];

    function automatic t_pix_item px(logic [15:0] u, logic [15:0] v, logic [15:0] gx,
                                     logic [15:0] gy, logic [15:0] gt, logic dr);
        return {u, v, gx, gy, gt, dr};
    endfunction

    initial begin
        t_pix_item pix [9];
        t_vel_res nores;
        logic [10:0] w, h;
        int phase;
        nores = '0;
        p_alpha = ofv_pkg::ALPHA_SQ_RST;
        p_width = ofv_pkg::FRAME_WIDTH_RST;
        p_height = ofv_pkg::FRAME_HEIGHT_RST;
        p_frow = ofv_pkg::FIRST_ROW_RST; p_lrow = ofv_pkg::LAST_ROW_RST;
        p_fcol = ofv_pkg::FIRST_COL_RST; p_lcol = ofv_pkg::LAST_COL_RST;
        foreach (up_ln[i]) begin
            up_ln[i] = '0; mid_ln[i] = '0; grad_ln[i] = '0;
        end
        foreach (win[i]) win[i] = '0;
        grad_dly = '0; col_n = 0; row_n = 0;

        pix[0] = px(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 0);
        pix[1] = px(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'hffff, 0);
        pix[2] = px(16'h0000, 16'hffff, 16'h0001, 16'h0000, 16'h7fff, 0);
        pix[3] = px(16'h0001, 16'h8000, 16'hffff, 16'hffff, 16'h8000, 0);
        pix[4] = px(16'h0100, 16'hff00, 16'h0100, 16'h0080, 16'h8000, 0);
        pix[5] = px(16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 0);
        pix[6] = px(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 0);
        pix[7] = px(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 0);
        pix[8] = px(16'h1234, 16'hedcb, 16'h5555, 16'haaaa, 16'h0f0f, 0);
        // a 3x3 frame: only the center pixel is updated, the rest copy through
        for (int k = 0; k < 4; k++) dir_tab[k] = {pix[k], 1'b0, nores};
        dir_tab[4] = {px(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1), 1'b0, nores};
        for (int k = 4; k < 9; k++)
            dir_tab[k + 1] = {pix[k], k != 8, {pix[k-4].u, pix[k-4].v, 1'b1, 1'b0}};
        dir_tab[10] = {px(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1), 1'b1,
                       {pix[5].u, pix[5].v, 1'b1, 1'b0}};
        // tail item without the drain flag, fields ignored
        dir_tab[11] = {px(16'hbeef, 16'hcafe, 16'h1111, 16'h2222, 16'h3333, 0), 1'b1,
                       {pix[6].u, pix[6].v, 1'b1, 1'b0}};
        dir_tab[12] = {px(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1), 1'b1,
                       {pix[7].u, pix[7].v, 1'b1, 1'b0}};
        dir_tab[13] = {px(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1), 1'b1,
                       {pix[8].u, pix[8].v, 1'b1, 1'b1}};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_regs(32'd1, 11'd3, 11'd3, 10'd1, 10'd1022, 10'd1, 10'd1022);
        foreach (dir_tab[k]) send_item(dir_tab[k].it, dir_tab[k].typed, dir_tab[k].r);
        wait_drained();

        phase = 0;
        while (items_sent < RAND_END) begin
            if (items_sent < RAND_END / 3) begin
                send_idle = 16; recv_idle = 69;
            end else if (items_sent < 2 * RAND_END / 3) begin
                send_idle = 69; recv_idle = 16;
            end else begin
                send_idle = 0; recv_idle = 0;
            end
            w = (($urandom % 20) == 0) ? 11'($urandom_range(0, 2)) : 11'($urandom_range(3, 8));
            h = (($urandom % 20) == 0) ? 11'($urandom_range(0, 2)) : 11'($urandom_range(3, 5));
            case (phase % 5)
                0: p_alpha = 32'd0;
                1: p_alpha = 32'hffffffff;
                2: p_alpha = $urandom_range(0, 262144);
                default: p_alpha = $urandom;
            endcase
            write_regs(p_alpha, w, h,
                       (($urandom % 6) == 0) ? 10'($urandom_range(1, 1022)) : 10'($urandom_range(1, 2)),
                       (($urandom % 6) == 0) ? 10'd1022 : 10'($urandom_range(1, 6)),
                       (($urandom % 6) == 0) ? 10'($urandom_range(1, 1022)) : 10'($urandom_range(1, 2)),
                       (($urandom % 6) == 0) ? 10'd1022 : 10'($urandom_range(1, 8)));
            repeat ($urandom_range(1, 3)) run_frame(($urandom % 10) == 0);
            wait_drained();
            phase++;
        end

        // width beyond the line limit and height below the minimum, first row only
        send_idle = 0; recv_idle = 0;
        write_regs($urandom, 11'd2047, 11'd0, 10'd1, 10'd1022, 10'd1, 10'd1022);
        for (int n = 0; n < WIDE_ITEMS; n++) send_item(rnd_item(0), 0, '0);
        wait_drained();

        $display("sent %0d items over %0d random phases and one over-wide frame", items_sent,
                 phase);
        $display("checked %0d results, %0d of them updated", results_seen, updated_seen);
        if (errors == 0 && vel_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
